FILE: rtl/aeps_pkg.sv
// Shared types and constants for the active/expired priority scheduler.
// No dependencies; imported by aeps_level_table, the top level and the testbench.
package aeps_pkg;

  localparam int NUM_LEVELS = 8;
  localparam int MAX_PROCS  = 64;
  localparam int PID_W      = 6;
  localparam int SP_W       = 4;
  localparam int DP_W       = 3;
  localparam int TS_W       = 24;
  localparam int LVL_W      = $clog2(NUM_LEVELS);
  localparam int IDX_W      = LVL_W + 1;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_NEXT    = 2'd1,
    OP_DECAY   = 2'd2,
    OP_PREEMPT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ
  } state_t;

  // update of the level table (head, tail, nonempty flag, bank swap); idx = {bank, level}
  typedef struct packed {
    logic             set_head;
    logic             set_tail;
    logic             set_ne;
    logic             clr_ne;
    logic             swap;
    logic [IDX_W-1:0] idx;
    logic [PID_W-1:0] head_val;
    logic [PID_W-1:0] tail_val;
  } lvl_cmd_t;

  typedef struct packed {
    logic             found;
    logic [PID_W-1:0] pid;
    logic [SP_W-1:0]  sp;
    logic [DP_W-1:0]  dp;
    logic             went_expired;
    logic             preempt;
    logic             error;
  } result_t;

endpackage

FILE: rtl/aeps_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module aeps_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/aeps_level_table.sv
// Per-level FIFO head/tail pointers, nonempty flags and active bank select.
// Depends on aeps_pkg.
module aeps_level_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [aeps_pkg::IDX_W-1:0]        rd_idx,
  input  aeps_pkg::lvl_cmd_t                cmd,
  output logic [aeps_pkg::PID_W-1:0]        head_rd,
  output logic [aeps_pkg::PID_W-1:0]        tail_rd,
  output logic [1:0][aeps_pkg::NUM_LEVELS-1:0] nonempty,
  output logic                              active_bank
);
  import aeps_pkg::*;

  logic [PID_W-1:0] head [2**IDX_W];
  logic [PID_W-1:0] tail [2**IDX_W];

  assign head_rd = head[rd_idx];
  assign tail_rd = tail[rd_idx];

  always_ff @(posedge clk) begin
    if (cmd.set_head) begin
      head[cmd.idx] <= cmd.head_val;
    end
    if (cmd.set_tail) begin
      tail[cmd.idx] <= cmd.tail_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nonempty    <= '0;
      active_bank <= 1'b0;
    end else begin
      if (cmd.swap) begin
        active_bank <= ~active_bank;
      end
      if (cmd.set_ne) begin
        nonempty[cmd.idx[LVL_W]][cmd.idx[LVL_W-1:0]] <= 1'b1;
      end
      if (cmd.clr_ne) begin
        nonempty[cmd.idx[LVL_W]][cmd.idx[LVL_W-1:0]] <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/active_expired_priority_scheduler.sv
// Top level of the active/expired multilevel priority scheduler.
// Depends on aeps_pkg, aeps_ram and aeps_level_table.
//
// A transaction is taken when start is high and busy is low. Its result
// appears on the result ports for one cycle with done high and cannot be
// stalled. Add, decay and preemption test pass from idle through the exec
// state back to idle, as does take next when both banks are empty. When it
// finds an id it also passes through the read state, because the link and
// static priority of the popped id come from the link and static RAMs, whose
// head pointer read is registered. The result of a transaction is shown in
// the first cycle in which busy is low again, so the next start can be taken then.
module active_expired_priority_scheduler (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  op,
  input  logic [aeps_pkg::PID_W-1:0]  pid,
  input  logic [aeps_pkg::SP_W-1:0]   stat_prio,
  input  logic [aeps_pkg::DP_W-1:0]   dyn_prio,
  input  logic                        minus,
  input  logic                        running_valid,
  input  logic [aeps_pkg::DP_W-1:0]   running_priority,
  input  logic [aeps_pkg::TS_W-1:0]   running_ts,
  input  logic [aeps_pkg::TS_W-1:0]   now,
  output logic                        done,
  output logic                        found,
  output logic [aeps_pkg::PID_W-1:0]  out_pid,
  output logic [aeps_pkg::SP_W-1:0]   out_stat_prio,
  output logic [aeps_pkg::DP_W-1:0]   out_dyn_prio,
  output logic                        went_expired,
  output logic                        preempt,
  output logic                        error
);
  import aeps_pkg::*;

  state_t state, state_next;

  op_t              r_op;
  logic [PID_W-1:0] r_pid;
  logic [SP_W-1:0]  r_sp;
  logic [DP_W-1:0]  r_dp;
  logic             r_minus;
  logic             r_rvalid;
  logic [DP_W-1:0]  r_rprio;
  logic [TS_W-1:0]  r_rts;
  logic [TS_W-1:0]  r_now;

  logic [PID_W-1:0] pop_pid;
  logic             pop_last;
  logic [IDX_W-1:0] pop_idx;

  result_t res, res_next;
  logic    res_load;

  lvl_cmd_t                    cmd;
  logic [IDX_W-1:0]            rd_idx;
  logic [PID_W-1:0]            head_rd;
  logic [PID_W-1:0]            tail_rd;
  logic [1:0][NUM_LEVELS-1:0]  nonempty;
  logic                        active_bank;

  logic             link_we;
  logic [PID_W-1:0] link_waddr;
  logic [PID_W-1:0] link_rd;
  logic             sp_we;
  logic [SP_W-1:0]  sp_rd;

  logic             do_push;
  logic             push_bank;
  logic [LVL_W-1:0] push_lvl;
  logic [IDX_W-1:0] push_idx;

  logic             next_go;
  logic             sel_bank;
  logic [NUM_LEVELS-1:0] sel_mask;
  logic [LVL_W-1:0] sel_lvl;
  logic [IDX_W-1:0] next_idx;
  logic [SP_W-1:0]  sp_m1;

  aeps_level_table u_levels (
    .clk         (clk),
    .rst         (rst),
    .rd_idx      (rd_idx),
    .cmd         (cmd),
    .head_rd     (head_rd),
    .tail_rd     (tail_rd),
    .nonempty    (nonempty),
    .active_bank (active_bank)
  );

  aeps_ram #(.WIDTH(PID_W), .DEPTH(MAX_PROCS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (r_pid),
    .raddr (head_rd),
    .rdata (link_rd)
  );

  aeps_ram #(.WIDTH(SP_W), .DEPTH(MAX_PROCS)) u_static_ram (
    .clk   (clk),
    .we    (sp_we),
    .waddr (r_pid),
    .wdata (r_sp),
    .raddr (head_rd),
    .rdata (sp_rd)
  );

  assign busy = (state != ST_IDLE);
  assign sp_m1 = r_sp - SP_W'(1);

  // bank and level selection for take next
  always_comb begin
    sel_bank = active_bank ^ (nonempty[active_bank] == '0);
    sel_mask = nonempty[sel_bank];
    sel_lvl  = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (sel_mask[i]) begin
        sel_lvl = LVL_W'(i);
      end
    end
    next_idx = {sel_bank, sel_lvl};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_EXEC;
      ST_EXEC: state_next = next_go ? ST_READ : ST_IDLE;
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    res_next  = '0;
    res_load  = 1'b0;
    next_go   = 1'b0;
    do_push   = 1'b0;
    push_bank = active_bank;
    push_lvl  = '0;
    cmd       = '0;
    link_we   = 1'b0;
    sp_we     = 1'b0;

    unique case (state)
      ST_EXEC: begin
        res_load = 1'b1;
        unique case (r_op)
          OP_ADD: begin
            if ({1'b0, r_dp} >= r_sp || 32'(r_dp) >= NUM_LEVELS ||
                32'(r_pid) >= MAX_PROCS) begin
              res_next.error = 1'b1;
            end else begin
              do_push  = 1'b1;
              push_lvl = r_dp[LVL_W-1:0];
            end
          end
          OP_NEXT: begin
            cmd.swap = (nonempty[active_bank] == '0);
            if (sel_mask != '0) begin
              next_go  = 1'b1;
              res_load = 1'b0;
            end
          end
          OP_DECAY: begin
            if (r_sp == '0 || 32'(r_sp) > NUM_LEVELS) begin
              res_next.error = 1'b1;
            end else if (r_minus && r_dp == '0) begin
              res_next.dp = sp_m1[DP_W-1:0];
              if (32'(r_pid) >= MAX_PROCS) begin
                res_next.error = 1'b1;
              end else begin
                do_push   = 1'b1;
                push_bank = ~active_bank;
                push_lvl  = sp_m1[LVL_W-1:0];
                res_next.went_expired = 1'b1;
              end
            end else if (r_minus) begin
              res_next.dp = r_dp - DP_W'(1);
            end else begin
              res_next.dp = sp_m1[DP_W-1:0];
            end
          end
          OP_PREEMPT: begin
            res_next.preempt = r_rvalid && (r_dp > r_rprio) && (r_rts > r_now);
          end
          default: ;
        endcase

        if (do_push) begin
          sp_we        = 1'b1;
          cmd.idx      = {push_bank, push_lvl};
          cmd.set_tail = 1'b1;
          cmd.tail_val = r_pid;
          if (nonempty[push_bank][push_lvl]) begin
            link_we = 1'b1;
          end else begin
            cmd.set_head = 1'b1;
            cmd.head_val = r_pid;
            cmd.set_ne   = 1'b1;
          end
        end
      end
      ST_READ: begin
        res_load       = 1'b1;
        res_next.found = 1'b1;
        res_next.pid   = pop_pid;
        res_next.sp    = sp_rd;
        res_next.dp    = DP_W'(pop_idx[LVL_W-1:0]);
        cmd.idx        = pop_idx;
        if (pop_last) begin
          cmd.clr_ne = 1'b1;
        end else begin
          cmd.set_head = 1'b1;
          cmd.head_val = link_rd;
        end
      end
      default: ;
    endcase
  end

  assign push_idx   = {push_bank, push_lvl};
  assign rd_idx     = (r_op == OP_NEXT) ? next_idx : push_idx;
  assign link_waddr = tail_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      r_op     <= op_t'(op);
      r_pid    <= pid;
      r_sp     <= stat_prio;
      r_dp     <= dyn_prio;
      r_minus  <= minus;
      r_rvalid <= running_valid;
      r_rprio  <= running_priority;
      r_rts    <= running_ts;
      r_now    <= now;
    end
    if (state == ST_EXEC) begin
      pop_pid  <= head_rd;
      pop_last <= (head_rd == tail_rd);
      pop_idx  <= next_idx;
    end
    if (res_load) begin
      res <= res_next;
    end else begin
      res <= '0;
    end
  end

  assign found         = res.found;
  assign out_pid       = res.pid;
  assign out_stat_prio = res.sp;
  assign out_dyn_prio  = res.dp;
  assign went_expired  = res.went_expired;
  assign preempt       = res.preempt;
  assign error         = res.error;

  a_read_after_exec: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> $past(state) == ST_EXEC)
    else $error("link read stage entered without dispatch");

  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_IDLE)
    else $error("result strobe while busy");

  a_found_not_error: assert property (@(posedge clk) disable iff (rst)
    done |-> !(found && error))
    else $error("dequeue reported together with error");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results for one transaction");

endmodule

FILE: sim/active_expired_priority_scheduler_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for active_expired_priority_scheduler.
// Depends on aeps_pkg and the RTL; drives directed then random transactions
// and checks every done strobe against a scoreboard that predicts each result.
module active_expired_priority_scheduler_tb;
  import aeps_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam int QUIET_TAIL   = 300;
  localparam int STALL_LIMIT  = 1000;

  typedef struct packed {
    op_t             op;
    logic [PID_W-1:0] pid;
    logic [SP_W-1:0]  sp;
    logic [DP_W-1:0]  dp;
    logic             minus;
    logic             rvalid;
    logic [DP_W-1:0]  rprio;
    logic [TS_W-1:0]  rts;
    logic [TS_W-1:0]  now;
  } sched_cmd_t;

  class sched_scoreboard;
    logic [PID_W-1:0]        link_mem [MAX_PROCS];
    bit                      link_valid [MAX_PROCS];
    logic [SP_W-1:0]         prio_mem [MAX_PROCS];
    logic [PID_W-1:0]        head_q [2*NUM_LEVELS];
    logic [PID_W-1:0]        tail_q [2*NUM_LEVELS];
    bit [2*NUM_LEVELS-1:0]   occupied;
    bit                      cur_bank;
    bit [MAX_PROCS-1:0]      held;
    result_t                 awaited[$];
    int unsigned             fails;

    function void enqueue(bit bank, int level, logic [PID_W-1:0] p, logic [SP_W-1:0] sp);
      int idx;
      idx = bank * NUM_LEVELS + level;
      prio_mem[p] = sp;
      held[p] = 1'b1;
      if (occupied[idx]) begin
        link_mem[tail_q[idx]] = p;
        link_valid[tail_q[idx]] = 1'b1;
        tail_q[idx] = p;
      end else begin
        head_q[idx] = p;
        tail_q[idx] = p;
        occupied[idx] = 1'b1;
      end
    endfunction

    // bank after a possible swap and the highest occupied level in it
    function bit locate_pop(output bit bank, output int idx);
      logic [NUM_LEVELS-1:0] m;
      int lvl;
      bank = cur_bank;
      if (occupied[bank*NUM_LEVELS +: NUM_LEVELS] == '0) bank = ~bank;
      m = occupied[bank*NUM_LEVELS +: NUM_LEVELS];
      lvl = 0;
      for (int l = 0; l < NUM_LEVELS; l++) if (m[l]) lvl = l;
      idx = bank * NUM_LEVELS + lvl;
      return m != '0;
    endfunction

    function bit pop_hits_unwritten_link();
      bit bank;
      int idx;
      if (!locate_pop(bank, idx)) return 1'b0;
      return head_q[idx] != tail_q[idx] && !link_valid[head_q[idx]];
    endfunction

    function void note_command(sched_cmd_t c);
      result_t r;
      bit bank;
      int idx;
      logic [PID_W-1:0] p;
      r = '0;
      case (c.op)
        OP_ADD: begin
          if (c.dp >= c.sp) r.error = 1'b1;
          else enqueue(cur_bank, int'(c.dp), c.pid, c.sp);
        end
        OP_NEXT: begin
          if (locate_pop(bank, idx)) begin
            p = head_q[idx];
            if (p == tail_q[idx]) occupied[idx] = 1'b0;
            else head_q[idx] = link_mem[p];
            held[p] = 1'b0;
            r.found = 1'b1;
            r.pid = p;
            r.sp = prio_mem[p];
            r.dp = DP_W'(idx % NUM_LEVELS);
          end
          cur_bank = bank;
        end
        OP_DECAY: begin
          if (c.sp == 0 || c.sp > NUM_LEVELS) begin
            r.error = 1'b1;
          end else if (!c.minus) begin
            r.dp = DP_W'(c.sp - SP_W'(1));
          end else if (c.dp != 0) begin
            r.dp = c.dp - DP_W'(1);
          end else begin
            r.dp = DP_W'(c.sp - SP_W'(1));
            r.went_expired = 1'b1;
            enqueue(~cur_bank, int'(c.sp) - 1, c.pid, c.sp);
          end
        end
        default: r.preempt = c.rvalid && c.dp > c.rprio && c.rts > c.now;
      endcase
      awaited.insert(awaited.size(), r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        fails++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result with no transaction awaiting it, pid %0d", $time, got.pid);
        fails++;
        return;
      end
      want = awaited[0];
      awaited.delete(0);
      compare_field("found", 8'(want.found), 8'(got.found));
      compare_field("out_pid", 8'(want.pid), 8'(got.pid));
      compare_field("out_stat_prio", 8'(want.sp), 8'(got.sp));
      compare_field("out_dyn_prio", 8'(want.dp), 8'(got.dp));
      compare_field("went_expired", 8'(want.went_expired), 8'(got.went_expired));
      compare_field("preempt", 8'(want.preempt), 8'(got.preempt));
      compare_field("error", 8'(want.error), 8'(got.error));
    endfunction
  endclass

  logic             clk;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       op = '0;
  logic [PID_W-1:0] pid = '0;
  logic [SP_W-1:0]  stat_prio = '0;
  logic [DP_W-1:0]  dyn_prio = '0;
  logic             minus = 1'b0;
  logic             running_valid = 1'b0;
  logic [DP_W-1:0]  running_priority = '0;
  logic [TS_W-1:0]  running_ts = '0;
  logic [TS_W-1:0]  now = '0;
  logic             done;
  logic             found;
  logic [PID_W-1:0] out_pid;
  logic [SP_W-1:0]  out_stat_prio;
  logic [DP_W-1:0]  out_dyn_prio;
  logic             went_expired;
  logic             preempt;
  logic             error;

  sched_scoreboard sb;
  bit              idling;
  int              stall_cycles;

  active_expired_priority_scheduler u_top (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .op               (op),
    .pid              (pid),
    .stat_prio        (stat_prio),
    .dyn_prio         (dyn_prio),
    .minus            (minus),
    .running_valid    (running_valid),
    .running_priority (running_priority),
    .running_ts       (running_ts),
    .now              (now),
    .done             (done),
    .found            (found),
    .out_pid          (out_pid),
    .out_stat_prio    (out_stat_prio),
    .out_dyn_prio     (out_dyn_prio),
    .went_expired     (went_expired),
    .preempt          (preempt),
    .error            (error)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result(result_t'({found, out_pid, out_stat_prio, out_dyn_prio,
                                 went_expired, preempt, error}));
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic sched_cmd_t random_fields();
    sched_cmd_t c;
    c.op = op_t'($urandom_range(0, 3));
    c.pid = PID_W'($urandom);
    c.sp = SP_W'($urandom);
    c.dp = DP_W'($urandom);
    c.minus = 1'($urandom);
    c.rvalid = 1'($urandom);
    c.rprio = DP_W'($urandom);
    c.rts = TS_W'($urandom);
    c.now = TS_W'($urandom);
    return c;
  endfunction

  function automatic sched_cmd_t sched_req(op_t o, int p, int s, int d, bit m);
    sched_cmd_t c;
    c = random_fields();
    c.op = o;
    c.pid = PID_W'(p);
    c.sp = SP_W'(s);
    c.dp = DP_W'(d);
    c.minus = m;
    return c;
  endfunction

  function automatic sched_cmd_t wake_req(int d, bit rv, int rp, int ts, int t);
    sched_cmd_t c;
    c = random_fields();
    c.op = OP_PREEMPT;
    c.dp = DP_W'(d);
    c.rvalid = rv;
    c.rprio = DP_W'(rp);
    c.rts = TS_W'(ts);
    c.now = TS_W'(t);
    return c;
  endfunction

  // mostly ids not currently queued, sometimes any id
  function automatic logic [PID_W-1:0] pick_pid();
    int first;
    first = $urandom_range(0, MAX_PROCS-1);
    if ($urandom_range(0, 9) != 0) begin
      for (int i = 0; i < MAX_PROCS; i++) begin
        if (!sb.held[(first + i) % MAX_PROCS]) return PID_W'((first + i) % MAX_PROCS);
      end
    end
    return PID_W'(first);
  endfunction

  function automatic sched_cmd_t random_cmd();
    sched_cmd_t c;
    int sel;
    c = random_fields();
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      c.op = OP_ADD;
      c.pid = pick_pid();
      if ($urandom_range(0, 9) != 0) begin
        c.sp = SP_W'($urandom_range(1, NUM_LEVELS));
        c.dp = DP_W'($urandom_range(0, int'(c.sp) - 1));
      end
    end else if (sel < 65) begin
      c.op = sb.pop_hits_unwritten_link() ? OP_PREEMPT : OP_NEXT;
    end else if (sel < 85) begin
      c.op = OP_DECAY;
      c.pid = pick_pid();
      if ($urandom_range(0, 9) != 0) c.sp = SP_W'($urandom_range(1, NUM_LEVELS));
      if ($urandom_range(0, 1) != 0) begin
        c.minus = 1'b1;
        c.dp = '0;
      end
    end else begin
      c.op = OP_PREEMPT;
      if ($urandom_range(0, 4) != 0) c.rvalid = 1'b1;
      case ($urandom_range(0, 3))
        0: c.rts = c.now;
        1: c.rprio = c.dp;
        default: ;
      endcase
    end
    return c;
  endfunction

  task automatic issue(sched_cmd_t c);
    if (idling && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start <= 1'b1;
    op <= c.op;
    pid <= c.pid;
    stat_prio <= c.sp;
    dyn_prio <= c.dp;
    minus <= c.minus;
    running_valid <= c.rvalid;
    running_priority <= c.rprio;
    running_ts <= c.rts;
    now <= c.now;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(c);
  endtask

  initial begin
    sb = new();
    idling = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue(sched_req(OP_NEXT, 0, 0, 0, 0));
    issue(sched_req(OP_ADD, 0, 1, 0, 0));
    issue(sched_req(OP_ADD, 63, 8, 7, 0));
    issue(sched_req(OP_ADD, 7, 3, 3, 1));
    issue(sched_req(OP_ADD, 8, 0, 0, 0));
    issue(sched_req(OP_ADD, 5, 15, 7, 0));
    issue(sched_req(OP_ADD, 9, 8, 7, 1));
    repeat (3) issue(sched_req(OP_NEXT, 0, 0, 0, 0));
    issue(sched_req(OP_DECAY, 12, 8, 0, 1));
    issue(sched_req(OP_DECAY, 13, 1, 0, 1));
    issue(sched_req(OP_DECAY, 1, 6, 5, 1));
    issue(sched_req(OP_DECAY, 2, 4, 2, 0));
    issue(sched_req(OP_DECAY, 3, 0, 0, 1));
    issue(sched_req(OP_DECAY, 4, 9, 0, 1));
    // active bank drains, then the banks swap
    repeat (3) issue(sched_req(OP_NEXT, 0, 0, 0, 0));
    // same id queued twice on one level
    repeat (2) issue(sched_req(OP_ADD, 20, 3, 2, 0));
    issue(sched_req(OP_NEXT, 0, 0, 0, 0));
    issue(wake_req(7, 1'b0, 0, 24'hFFFFFF, 0));
    issue(wake_req(7, 1'b1, 6, 24'hFFFFFF, 0));
    issue(wake_req(3, 1'b1, 3, 100, 50));
    issue(wake_req(4, 1'b1, 0, 24'h800000, 24'h800000));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= RANDOM_ITEMS - QUIET_TAIL) idling = 1'b0;
      else if ($urandom_range(0, 39) == 0) idling = ~idling;
      issue(random_cmd());
    end
    start <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
